[src/crc8_framed_command_receiver_top_macros.svh]
// Assertion macros for the frame receiver parser.
`ifndef CRC8_FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH
`define CRC8_FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH

// General form: the clock and reset are named explicitly.
`define CFR_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) \
    else $error(msg);

// Short form for modules whose clock is clk and reset is rst.
`define CFR_ASSERT_CLK(label, prop, msg) `CFR_ASSERT(label, clk, rst, prop, msg)

`endif

[src/cfr_pkg.sv]
// Types, codes and the CRC-8 update function for the frame receiver.
package cfr_pkg;

  localparam int PAYLOAD_DEPTH = 64;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Input item codes.
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  // Receiver phases.
  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CRC  = 3'd3;
  localparam logic [2:0] PH_OK   = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_COMMAND = 3'd1;
  localparam logic [2:0] ERR_LENGTH  = 3'd2;
  localparam logic [2:0] ERR_CRC     = 3'd4;
  localparam logic [2:0] ERR_TIMEOUT = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEVICE   = 2'd0;
  localparam logic [1:0] REG_SETTINGS = 2'd1;
  localparam logic [1:0] REG_DATA     = 2'd2;

  localparam logic [7:0] DEVICE_CODE_RST   = 8'd1;
  localparam logic [7:0] SETTINGS_CODE_RST = 8'd2;
  localparam logic [7:0] DATA_CODE_RST     = 8'd3;

  typedef struct packed {
    logic [7:0] device_code;
    logic [7:0] settings_code;
    logic [7:0] data_code;
  } cfg_t;

  typedef struct packed {
    logic       frame_ok;
    logic       frame_error;
    logic [2:0] error_code;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [5:0] payload_index;
    logic [2:0] receiver_phase;
  } result_t;

  // Reflected CRC-8 update over one byte, least significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

[src/crc8_framed_command_receiver_top.sv]
// The result of an accepted input transfer is loaded into the output register in the next cycle.
// One item is accepted per cycle while the input is not stalled; the state update and CRC-8 step are combinational.
// The input stalls only while a finished result waits on a stalled output.
// Reset (synchronous, active high) returns the receiver to the wait phase with clear
// CRC and held fields, empties the output register and loads the default command codes.
module crc8_framed_command_receiver_top #(
  parameter int PAYLOAD_DEPTH = cfr_pkg::PAYLOAD_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ok,
  output logic        frame_error,
  output logic [2:0]  error_code,
  output logic [7:0]  frame_command,
  output logic [7:0]  frame_length,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic [5:0]  payload_index,
  output logic [2:0]  receiver_phase,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfr_pkg::cfg_t    cfg;
  cfr_pkg::result_t res_comb;
  cfr_pkg::result_t res_reg;
  logic             step;
  logic             busy;

  assign in_stall = busy;
  assign step     = in_valid && !busy;

  cfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfr_parser #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .command    (command),
    .byte_value (byte_value),
    .cfg        (cfg),
    .res        (res_comb)
  );

  cfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_comb),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .res_out   (res_reg)
  );

  assign frame_ok       = res_reg.frame_ok;
  assign frame_error    = res_reg.frame_error;
  assign error_code     = res_reg.error_code;
  assign frame_command  = res_reg.frame_command;
  assign frame_length   = res_reg.frame_length;
  assign payload_byte   = res_reg.payload_byte;
  assign payload_valid  = res_reg.payload_valid;
  assign payload_index  = res_reg.payload_index;
  assign receiver_phase = res_reg.receiver_phase;

endmodule

[src/cfr_cfg_regs.sv]
// Register file for the three accepted command codes, on an APB-style port.
module cfr_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfr_pkg::cfg_t cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_code   <= cfr_pkg::DEVICE_CODE_RST;
      cfg.settings_code <= cfr_pkg::SETTINGS_CODE_RST;
      cfg.data_code     <= cfr_pkg::DATA_CODE_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        cfr_pkg::REG_DEVICE:   cfg.device_code   <= pwdata[7:0];
        cfr_pkg::REG_SETTINGS: cfg.settings_code <= pwdata[7:0];
        cfr_pkg::REG_DATA:     cfg.data_code     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      cfr_pkg::REG_DEVICE:   prdata = {24'd0, cfg.device_code};
      cfr_pkg::REG_SETTINGS: prdata = {24'd0, cfg.settings_code};
      cfr_pkg::REG_DATA:     prdata = {24'd0, cfg.data_code};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

[src/cfr_parser.sv]
// Frame state machine: phase, byte count, running CRC and held frame fields.
`include "crc8_framed_command_receiver_top_macros.svh"

module cfr_parser #(
  parameter int PAYLOAD_DEPTH = cfr_pkg::PAYLOAD_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [1:0]       command,
  input  logic [7:0]       byte_value,
  input  cfr_pkg::cfg_t    cfg,
  output cfr_pkg::result_t res
);

  logic [2:0] phase, phase_next;
  logic [7:0] byte_count, byte_count_next;
  logic [7:0] running_crc, running_crc_next;
  logic [7:0] held_command, held_command_next;
  logic [7:0] held_length, held_length_next;
  logic [2:0] held_error, held_error_next;

  logic [7:0] crc_upd;
  logic [7:0] count_inc;
  logic       code_match;

  assign crc_upd    = cfr_pkg::crc8_update(running_crc, byte_value);
  assign count_inc  = byte_count + 8'd1;
  assign code_match = (byte_value == cfg.device_code) ||
                      (byte_value == cfg.settings_code) ||
                      (byte_value == cfg.data_code);

  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    held_command_next = held_command;
    held_length_next  = held_length;
    held_error_next   = held_error;
    res               = '0;

    unique case (command)
      cfr_pkg::CMD_BYTE: begin
        unique case (phase)
          cfr_pkg::PH_WAIT: begin
            held_command_next = byte_value;
            running_crc_next  = crc_upd;
            byte_count_next   = 8'd0;
            if (code_match) begin
              phase_next = cfr_pkg::PH_LEN;
            end else begin
              phase_next      = cfr_pkg::PH_ERR;
              held_error_next = cfr_pkg::ERR_COMMAND;
              res.frame_error = 1'b1;
            end
          end
          cfr_pkg::PH_LEN: begin
            held_length_next = byte_value;
            running_crc_next = crc_upd;
            byte_count_next  = 8'd0;
            if (byte_value > 8'(PAYLOAD_DEPTH)) begin
              phase_next      = cfr_pkg::PH_ERR;
              held_error_next = cfr_pkg::ERR_LENGTH;
              res.frame_error = 1'b1;
            end else if (byte_value != 8'd0) begin
              phase_next = cfr_pkg::PH_DATA;
            end else begin
              phase_next = cfr_pkg::PH_CRC;
            end
          end
          cfr_pkg::PH_DATA: begin
            res.payload_valid = 1'b1;
            res.payload_byte  = byte_value;
            res.payload_index = byte_count[5:0];
            running_crc_next  = crc_upd;
            if (count_inc >= held_length) begin
              phase_next      = cfr_pkg::PH_CRC;
              byte_count_next = 8'd0;
            end else begin
              byte_count_next = count_inc;
            end
          end
          cfr_pkg::PH_CRC: begin
            byte_count_next = 8'd0;
            if (byte_value == running_crc) begin
              phase_next      = cfr_pkg::PH_OK;
              held_error_next = cfr_pkg::ERR_NONE;
              res.frame_ok    = 1'b1;
            end else begin
              phase_next      = cfr_pkg::PH_ERR;
              held_error_next = cfr_pkg::ERR_CRC;
              res.frame_error = 1'b1;
            end
          end
          default: ;
        endcase
      end
      cfr_pkg::CMD_TICK: begin
        // A timeout only counts once the payload has started.
        if (phase == cfr_pkg::PH_DATA && byte_count != 8'd0) begin
          phase_next      = cfr_pkg::PH_ERR;
          held_error_next = cfr_pkg::ERR_TIMEOUT;
          byte_count_next = 8'd0;
          res.frame_error = 1'b1;
        end
      end
      cfr_pkg::CMD_RELEASE: begin
        if (phase == cfr_pkg::PH_OK || phase == cfr_pkg::PH_ERR) begin
          phase_next        = cfr_pkg::PH_WAIT;
          byte_count_next   = 8'd0;
          running_crc_next  = 8'd0;
          held_command_next = 8'd0;
          held_length_next  = 8'd0;
          held_error_next   = cfr_pkg::ERR_NONE;
        end
      end
      default: ;
    endcase

    res.error_code     = held_error_next;
    res.frame_command  = held_command_next;
    res.frame_length   = held_length_next;
    res.receiver_phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cfr_pkg::PH_WAIT;
      byte_count   <= 8'd0;
      running_crc  <= 8'd0;
      held_command <= 8'd0;
      held_length  <= 8'd0;
      held_error   <= cfr_pkg::ERR_NONE;
    end else if (step) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      held_command <= held_command_next;
      held_length  <= held_length_next;
      held_error   <= held_error_next;
    end
  end

  `CFR_ASSERT_CLK(a_ok_enters_success, step && res.frame_ok |=> phase == cfr_pkg::PH_OK, "frame_ok without success phase")
  `CFR_ASSERT_CLK(a_count_below_length, phase == cfr_pkg::PH_DATA |-> byte_count < held_length, "payload count reached length in data phase")
  `CFR_ASSERT_CLK(a_error_only_in_err, held_error != cfr_pkg::ERR_NONE |-> phase == cfr_pkg::PH_ERR, "error code held outside error phase")

endmodule

[src/cfr_out_reg.sv]
// Result register with valid/stall handshake on the output side.
module cfr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  cfr_pkg::result_t res_in,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             busy,
  output cfr_pkg::result_t res_out
);

  // The register can take a new result unless it holds one that is stalled.
  assign busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[dv/tb_crc8_framed_command_receiver_top.sv]
// Self-checking testbench for the CRC-8 framed command receiver.
module tb_crc8_framed_command_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] value;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = cfr_pkg::CMD_BYTE;
  logic [7:0]  byte_value = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        frame_ok;
  logic        frame_error;
  logic [2:0]  error_code;
  logic [7:0]  frame_command;
  logic [7:0]  frame_length;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic [5:0]  payload_index;
  logic [2:0]  receiver_phase;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  crc8_framed_command_receiver_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_ok(frame_ok), .frame_error(frame_error), .error_code(error_code),
    .frame_command(frame_command), .frame_length(frame_length),
    .payload_byte(payload_byte), .payload_valid(payload_valid),
    .payload_index(payload_index), .receiver_phase(receiver_phase),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5ns clk = ~clk;

  // Receiver state as the testbench expects it to be.
  logic [7:0] cmd_code [3] = '{cfr_pkg::DEVICE_CODE_RST, cfr_pkg::SETTINGS_CODE_RST,
                               cfr_pkg::DATA_CODE_RST};
  logic [2:0] rx_phase  = cfr_pkg::PH_WAIT;
  logic [7:0] rx_count  = 8'd0;
  logic [7:0] rx_crc    = 8'd0;
  logic [7:0] rx_command = 8'd0;
  logic [7:0] rx_length = 8'd0;
  logic [2:0] rx_error  = cfr_pkg::ERR_NONE;

  rx_item_t          rx_items[$];
  cfr_pkg::result_t  predicted_results[$];

  int  item_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  mismatch_count = 0;
  int  frames_passed = 0;
  int  frames_failed = 0;
  int  settings_count = 1;
  int  cycle_count = 0;
  int  input_stall_cycles = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  bit  calm = 1'b0;
  int  gap_left = 0;
  int  driver_roll;
  int  stall_left = 0;
  int  stall_roll;

  function automatic logic [7:0] maxim_crc8_step(logic [7:0] crc, logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ cfr_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  function automatic void abort_frame(logic [2:0] code);
    rx_error = code;
    rx_phase = cfr_pkg::PH_ERR;
    rx_count = 8'd0;
  endfunction

  // Advances the expected receiver state by one item and returns its result.
  function automatic cfr_pkg::result_t predict_frame_step(logic [1:0] cmd, logic [7:0] b);
    cfr_pkg::result_t r;
    r = '0;
    case (cmd)
      cfr_pkg::CMD_BYTE: begin
        case (rx_phase)
          cfr_pkg::PH_WAIT: begin
            rx_command = b;
            rx_crc = maxim_crc8_step(rx_crc, b);
            if (b == cmd_code[cfr_pkg::REG_DEVICE] || b == cmd_code[cfr_pkg::REG_SETTINGS] ||
                b == cmd_code[cfr_pkg::REG_DATA]) begin
              rx_phase = cfr_pkg::PH_LEN;
              rx_count = 8'd0;
            end else begin
              abort_frame(cfr_pkg::ERR_COMMAND);
              r.frame_error = 1'b1;
            end
          end
          cfr_pkg::PH_LEN: begin
            rx_length = b;
            rx_crc = maxim_crc8_step(rx_crc, b);
            rx_count = 8'd0;
            if (b > cfr_pkg::PAYLOAD_DEPTH) begin
              abort_frame(cfr_pkg::ERR_LENGTH);
              r.frame_error = 1'b1;
            end else if (b != 8'd0) begin
              rx_phase = cfr_pkg::PH_DATA;
            end else begin
              rx_phase = cfr_pkg::PH_CRC;
            end
          end
          cfr_pkg::PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = rx_count[5:0];
            rx_crc = maxim_crc8_step(rx_crc, b);
            rx_count = rx_count + 8'd1;
            if (rx_count >= rx_length) begin
              rx_phase = cfr_pkg::PH_CRC;
              rx_count = 8'd0;
            end
          end
          cfr_pkg::PH_CRC: begin
            if (b == rx_crc) begin
              rx_phase = cfr_pkg::PH_OK;
              rx_error = cfr_pkg::ERR_NONE;
              rx_count = 8'd0;
              r.frame_ok = 1'b1;
            end else begin
              abort_frame(cfr_pkg::ERR_CRC);
              r.frame_error = 1'b1;
            end
          end
          default: ;
        endcase
      end
      cfr_pkg::CMD_TICK: begin
        if (rx_phase == cfr_pkg::PH_DATA && rx_count != 8'd0) begin
          abort_frame(cfr_pkg::ERR_TIMEOUT);
          r.frame_error = 1'b1;
        end
      end
      cfr_pkg::CMD_RELEASE: begin
        if (rx_phase == cfr_pkg::PH_OK || rx_phase == cfr_pkg::PH_ERR) begin
          rx_phase = cfr_pkg::PH_WAIT;
          rx_count = 8'd0;
          rx_crc = 8'd0;
          rx_command = 8'd0;
          rx_length = 8'd0;
          rx_error = cfr_pkg::ERR_NONE;
        end
      end
      default: ;
    endcase
    r.error_code = rx_error;
    r.frame_command = rx_command;
    r.frame_length = rx_length;
    r.receiver_phase = rx_phase;
    return r;
  endfunction

  // Sender: offers queued items and predicts each one at its transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      command <= cfr_pkg::CMD_BYTE;
      byte_value <= 8'd0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(predict_frame_step(command, byte_value));
        accepted_count++;
        driver_roll = $urandom_range(0, 99);
        if (calm || driver_roll < 65) begin
          gap_left = 0;
        end else if (driver_roll < 95) begin
          gap_left = $urandom_range(1, 3);
        end else begin
          gap_left = $urandom_range(8, 25);
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rx_items.size() > 0) begin
          command <= rx_items[0].cmd;
          byte_value <= rx_items[0].value;
          in_valid <= 1'b1;
          void'(rx_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, including the long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_roll = $urandom_range(0, 99);
        if (holds_served < hold_requests) begin
          holds_served++;
          stall_left = HOLD_CYCLES;
        end else if (!calm && stall_roll >= 97) begin
          stall_left = $urandom_range(10, 30);
        end else if (!calm && stall_roll >= 70) begin
          stall_left = $urandom_range(1, 3);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    cfr_pkg::result_t got;
    cfr_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {frame_ok, frame_error, error_code, frame_command, frame_length,
             payload_byte, payload_valid, payload_index, receiver_phase};
      result_count++;
      if (got.frame_ok) frames_passed++;
      if (got.frame_error) frames_failed++;
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result %0d arrived with no transfer outstanding", result_count);
        end
      end else begin
        want = predicted_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d mismatch: ok/err/code/cmd/len/byte/pv/idx/phase",
                     result_count);
            $display("  expected %0b %0b %0d %02h %02h %02h %0b %0d %0d",
                     want.frame_ok, want.frame_error, want.error_code, want.frame_command,
                     want.frame_length, want.payload_byte, want.payload_valid,
                     want.payload_index, want.receiver_phase);
            $display("  actual   %0b %0b %0d %02h %02h %02h %0b %0d %0d",
                     got.frame_ok, got.frame_error, got.error_code, got.frame_command,
                     got.frame_length, got.payload_byte, got.payload_valid,
                     got.payload_index, got.receiver_phase);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_stall) input_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("crc8_framed_command_receiver_top regression: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] value);
    rx_items.push_back('{cmd, value});
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  // A whole frame from the wait phase, then up to two held-phase items and a release.
  // A tick placed before payload byte tick_at times the frame out when 0 < tick_at < len.
  task automatic queue_frame(input logic [7:0] code, input int len, input bit good_crc,
                             input int tick_at);
    logic [7:0] crc;
    logic [7:0] data;
    crc = maxim_crc8_step(8'h00, code);
    queue_item(cfr_pkg::CMD_BYTE, code);
    crc = maxim_crc8_step(crc, len[7:0]);
    queue_item(cfr_pkg::CMD_BYTE, len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (i == tick_at) queue_item(cfr_pkg::CMD_TICK, 8'($urandom));
      if ($urandom_range(0, 29) == 0) queue_item(CMD_UNUSED, 8'($urandom));
      data = 8'($urandom);
      crc = maxim_crc8_step(crc, data);
      queue_item(cfr_pkg::CMD_BYTE, data);
    end
    if (tick_at == len) queue_item(cfr_pkg::CMD_TICK, 8'($urandom));
    queue_item(cfr_pkg::CMD_BYTE, good_crc ? crc : crc ^ (8'h01 << $urandom_range(0, 7)));
    repeat ($urandom_range(0, 2)) begin
      queue_item($urandom_range(0, 1) ? cfr_pkg::CMD_BYTE : cfr_pkg::CMD_TICK,
                 8'($urandom));
    end
    queue_item(cfr_pkg::CMD_RELEASE, 8'($urandom));
  endtask

  task automatic queue_random_traffic(input int n);
    int start;
    int pick;
    int len;
    int tick_at;
    logic [7:0] code;
    logic [7:0] bad;
    start = item_count;
    while (item_count - start < n) begin
      pick = $urandom_range(0, 99);
      code = cmd_code[$urandom_range(0, 2)];
      if (pick < 72) begin
        if ($urandom_range(0, 59) == 0) begin
          len = $urandom_range(0, 1) ? cfr_pkg::PAYLOAD_DEPTH :
                                       $urandom_range(9, cfr_pkg::PAYLOAD_DEPTH - 1);
        end else begin
          len = $urandom_range(0, 8);
        end
        tick_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
        queue_frame(code, len, $urandom_range(0, 7) != 0, tick_at);
      end else if (pick < 84) begin
        do bad = 8'($urandom); while (bad == cmd_code[cfr_pkg::REG_DEVICE] ||
                                      bad == cmd_code[cfr_pkg::REG_SETTINGS] ||
                                      bad == cmd_code[cfr_pkg::REG_DATA]);
        queue_item(cfr_pkg::CMD_BYTE, bad);
        repeat ($urandom_range(0, 2)) queue_item(cfr_pkg::CMD_BYTE, 8'($urandom));
        queue_item(cfr_pkg::CMD_RELEASE, 8'($urandom));
      end else if (pick < 92) begin
        queue_item(cfr_pkg::CMD_BYTE, code);
        queue_item(cfr_pkg::CMD_BYTE, 8'($urandom_range(cfr_pkg::PAYLOAD_DEPTH + 1, 255)));
        queue_item(cfr_pkg::CMD_RELEASE, 8'($urandom));
      end else begin
        // Noise: may leave the receiver part-way through a frame.
        repeat ($urandom_range(1, 6)) queue_item(2'($urandom_range(0, 3)), 8'($urandom));
        queue_item(cfr_pkg::CMD_RELEASE, 8'($urandom));
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (rx_items.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  task automatic write_code(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cmd_code[idx] = value;
  endtask

  task automatic write_codes(input logic [7:0] dev, input logic [7:0] set,
                             input logic [7:0] dat);
    wait_until_drained();
    repeat (3) @(posedge clk);
    write_code(cfr_pkg::REG_DEVICE, dev);
    write_code(cfr_pkg::REG_SETTINGS, set);
    write_code(cfr_pkg::REG_DATA, dat);
    settings_count++;
    @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ignored items, each error, and the zero-length frame.
    queue_item(cfr_pkg::CMD_RELEASE, 8'h00);
    queue_item(cfr_pkg::CMD_TICK, 8'hFF);
    queue_item(CMD_UNUSED, 8'hAA);
    queue_item(cfr_pkg::CMD_BYTE, 8'hFF);
    queue_item(cfr_pkg::CMD_BYTE, 8'h00);
    queue_item(cfr_pkg::CMD_TICK, 8'h55);
    queue_item(cfr_pkg::CMD_RELEASE, 8'hFF);
    queue_frame(cfr_pkg::DEVICE_CODE_RST, 0, 1'b1, -1);
    queue_item(cfr_pkg::CMD_BYTE, cfr_pkg::DATA_CODE_RST);
    queue_item(cfr_pkg::CMD_BYTE, 8'd65);
    queue_item(cfr_pkg::CMD_RELEASE, 8'h00);
    queue_item(cfr_pkg::CMD_BYTE, cfr_pkg::SETTINGS_CODE_RST);
    queue_item(cfr_pkg::CMD_BYTE, 8'hFF);
    queue_item(cfr_pkg::CMD_RELEASE, 8'h00);
    queue_frame(cfr_pkg::SETTINGS_CODE_RST, 2, 1'b1, 0);
    queue_frame(cfr_pkg::DATA_CODE_RST, 3, 1'b1, 1);
    queue_frame(cfr_pkg::DATA_CODE_RST, 1, 1'b0, -1);
    queue_frame(cfr_pkg::DEVICE_CODE_RST, cfr_pkg::PAYLOAD_DEPTH, 1'b1, -1);
    queue_random_traffic(150);

    // Extreme codes, with neither side idling.
    write_codes(8'h00, 8'hFF, 8'h80);
    calm = 1'b1;
    queue_random_traffic(215);
    wait_until_drained();
    calm = 1'b0;

    // A long receiver hold-off while the sender keeps offering transfers.
    write_codes(8'hFF, 8'h00, 8'h00);
    queue_random_traffic(100);
    hold_requests++;
    queue_random_traffic(115);

    // Sender pauses part-way until every result is back.
    write_codes(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_traffic(100);
    wait_until_drained();
    queue_random_traffic(115);

    write_codes(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_traffic(215);

    wait_until_drained();
    repeat (4) @(posedge clk);
    if (predicted_results.size() != 0) begin
      mismatch_count += predicted_results.size();
      $display("%0d results never arrived", predicted_results.size());
    end
    $display("checked %0d transfers over %0d command-code settings", result_count,
             settings_count);
    $display("%0d frames passed CRC, %0d frame errors, input stalled for %0d cycles",
             frames_passed, frames_failed, input_stall_cycles);
    $display("%0d long receiver hold-offs; %0d mismatches", holds_served, mismatch_count);
    if (mismatch_count == 0) begin
      $display("crc8_framed_command_receiver_top regression: pass");
    end else begin
      $display("crc8_framed_command_receiver_top regression: fail");
    end
    $finish;
  end

endmodule
